/* rtl/stpq_pkg.sv */
// ============================================================================
// stpq_pkg
// Shared types and constants of the stable priority task queue.
// ============================================================================
package stpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int OP_W   = 2;
    localparam int TAG_W  = 8;
    localparam int PRI_W  = 8;
    localparam int RUN_W  = 16;
    localparam int KIND_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LIST   = 2'd1,
        OP_DRAIN  = 2'd2
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENTRY  = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] pri;
        logic [RUN_W-1:0] run;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage

/* rtl/stpq_if.sv */
// ============================================================================
// stpq_in_if / stpq_out_if
// Valid/ready channels carrying queue operations and queue results.
// ============================================================================
interface stpq_in_if import stpq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [TAG_W-1:0] task_tag;
    logic [PRI_W-1:0] priority_req;
    logic [RUN_W-1:0] run_time;

    modport source (output valid, operation, task_tag, priority_req, run_time,
                    input ready);
    modport sink   (input valid, operation, task_tag, priority_req, run_time,
                    output ready);
endinterface

interface stpq_out_if import stpq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  task_tag_res;
    logic [PRI_W-1:0]  priority_res;
    logic [RUN_W-1:0]  run_time_res;
    logic              last;

    modport source (output valid, kind, task_tag_res, priority_res, run_time_res, last,
                    input ready);
    modport sink   (input valid, kind, task_tag_res, priority_res, run_time_res, last,
                    output ready);
endinterface

/* rtl/stpq_store.sv */
// ============================================================================
// stpq_store
// Task storage: one write port, one read port with registered read data.
// ============================================================================
module stpq_store import stpq_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_mem,
    output t_entry   o_rdata
);

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.waddr] <= i_mem.wdata;
        end
        r_rdata <= r_mem[i_mem.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/stpq_ctrl.sv */
// ============================================================================
// stpq_ctrl
// Sequencer: shifts entries during insert with one priority compare per
// cycle, walks the store for list and drain, and holds the result register.
// ============================================================================
module stpq_ctrl import stpq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stpq_in_if.sink    i_req,
    stpq_out_if.source o_res,
    output t_mem_req   o_mem,
    input  t_entry     i_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_LD,
        S_ACK
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    t_entry           r_new;
    logic             r_drain;
    t_kind            r_ack_kind;
    logic             r_out_valid;
    t_kind            r_out_kind;
    t_entry           r_out_entry;
    logic             r_out_last;

    logic   in_acc;
    logic   out_free;
    logic   shift;
    logic   is_last;
    t_entry in_entry;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign in_entry    = '{tag: i_req.task_tag, pri: i_req.priority_req,
                           run: i_req.run_time};
    // stored entry of lower priority moves one slot back
    assign shift       = (i_rdata.pri < r_new.pri);
    assign is_last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    always_comb begin
        o_mem.we    = 1'b0;
        o_mem.waddr = r_idx + IDX_W'(1);
        o_mem.wdata = r_new;
        o_mem.raddr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_mem.raddr = IDX_W'(r_count - CNT_W'(1));
                if (in_acc && (i_req.operation == OP_INSERT) && (r_count == '0)) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = '0;
                    o_mem.wdata = in_entry;
                end
                if (i_req.operation != OP_INSERT) begin
                    o_mem.raddr = '0;
                end
            end
            S_INS: begin
                o_mem.we = 1'b1;
                if (shift) begin
                    o_mem.wdata = i_rdata;
                    o_mem.raddr = r_idx - IDX_W'(1);
                end
            end
            S_PUT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = '0;
            end
            S_LD: begin
                // advance the read only when the result register takes this entry
                o_mem.raddr = out_free ? (r_idx + IDX_W'(1)) : r_idx;
            end
            S_ACK: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_new <= in_entry;
                        unique case (i_req.operation)
                            OP_INSERT: begin
                                r_ack_kind <= KIND_ACCEPT;
                                if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                    r_ack_kind <= KIND_REJECT;
                                    r_state    <= S_ACK;
                                end else if (r_count == '0) begin
                                    r_count <= CNT_W'(1);
                                    r_state <= S_ACK;
                                end else begin
                                    r_idx   <= IDX_W'(r_count - CNT_W'(1));
                                    r_state <= S_INS;
                                end
                            end
                            OP_LIST, OP_DRAIN: begin
                                r_drain <= (i_req.operation == OP_DRAIN);
                                r_idx   <= '0;
                                if (r_count == '0) begin
                                    r_ack_kind <= KIND_EMPTY;
                                    r_state    <= S_ACK;
                                end else begin
                                    r_state <= S_LD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_INS: begin
                    if (shift) begin
                        if (r_idx == '0) begin
                            r_state <= S_PUT;
                        end else begin
                            r_idx <= r_idx - IDX_W'(1);
                        end
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_ACK;
                    end
                end
                S_PUT: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_ACK;
                end
                S_LD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_ENTRY;
                        r_out_entry <= i_rdata;
                        r_out_last  <= is_last;
                        r_idx       <= r_idx + IDX_W'(1);
                        if (is_last) begin
                            r_state <= S_IDLE;
                            if (r_drain) begin
                                r_count <= '0;
                            end
                        end
                    end
                end
                S_ACK: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_ack_kind;
                        r_out_entry <= '0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out_kind;
    assign o_res.task_tag_res = r_out_entry.tag;
    assign o_res.priority_res = r_out_entry.pri;
    assign o_res.run_time_res = r_out_entry.run;
    assign o_res.last         = r_out_last;

endmodule

/* rtl/stable_priority_task_queue_unit.sv */
// ============================================================================
// stable_priority_task_queue_unit
// Bounded task queue kept sorted by priority, highest first, stable among
// equal priorities; supports insert, list and drain.
// ============================================================================
//
//  channel | dir | payload                                          | transfer
//  --------+-----+--------------------------------------------------+------------------
//  i_req   | in  | operation, task_tag, priority_req, run_time      | valid && ready
//  o_res   | out | kind, task_tag_res, priority_res, run_time_res,  | valid && ready
//          |     | last                                             |
//
//  Insert: the sequencer compares and moves one stored entry per cycle through
//  the single store port pair, walking back over the stored tasks of lower
//  priority; an insert into an empty queue and a rejected insert skip the walk.
//  List and drain give one entry per cycle out of the registered read port
//  while each result is taken; on an empty queue they give one empty marker.
//  Reset: the task count clears on a synchronous reset; the store holds no reset.
//  Stalls: a held result stops the sequencer when it loads a list entry or an
//  acknowledgement; i_req.ready is low while an operation is in progress and
//  high again once its final result is loaded.
module stable_priority_task_queue_unit import stpq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stpq_in_if.sink    i_req,
    stpq_out_if.source o_res
);

    // request and read data between sequencer and store
    t_mem_req mem_req;
    t_entry   mem_rdata;

    // sequencer: compare, shift and output register
    stpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_res   (o_res),
        .o_mem   (mem_req),
        .i_rdata (mem_rdata)
    );

    // task words, sorted front to back
    stpq_store u_store (
        .i_clk   (i_clk),
        .i_mem   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

/* rtl/stpq_chk.sv */
// ============================================================================
// stpq_chk
// Port-level checks of the task queue, bound to the top level.
// ============================================================================
module stpq_chk import stpq_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [OP_W-1:0]   i_in_op,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [KIND_W-1:0] i_out_kind,
    input logic [TAG_W-1:0]  i_out_tag,
    input logic [PRI_W-1:0]  i_out_pri,
    input logic [RUN_W-1:0]  i_out_run,
    input logic              i_out_last
);

    logic in_xfer;
    assign in_xfer = i_in_valid && i_in_ready;

    // held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid &&
            $stable({i_out_kind, i_out_tag, i_out_pri, i_out_run, i_out_last})))
        else $error("stalled result changed");

    // a valid operation blocks the request side in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in_op == OP_INSERT || i_in_op == OP_LIST ||
                     i_in_op == OP_DRAIN)) |=> !i_in_ready)
        else $error("request accepted while an operation is in progress");

    // an unused operation code leaves the queue ready
    a_unused_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !(i_in_op == OP_INSERT || i_in_op == OP_LIST ||
                      i_in_op == OP_DRAIN)) |=> i_in_ready)
        else $error("unused operation code stalled the queue");

    // markers and acknowledgements are single, zero-payload results
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind != KIND_ENTRY)) |->
            (i_out_last && i_out_tag == '0 && i_out_pri == '0 && i_out_run == '0))
        else $error("non-entry result with payload or without last");

    // no new request while a listing is still in flight
    a_listing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_in_ready)
        else $error("ready during a listing");

endmodule

bind stable_priority_task_queue_unit stpq_chk u_stpq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_op     (i_req.operation),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_kind  (o_res.kind),
    .i_out_tag   (o_res.task_tag_res),
    .i_out_pri   (o_res.priority_res),
    .i_out_run   (o_res.run_time_res),
    .i_out_last  (o_res.last)
);
